// File: rtl/wrp_pkg.sv
// shared types, constants and the power-of-27 table of the radix-27 word packer
package wrp_pkg;

  localparam int unsigned WordW     = 62;
  localparam int unsigned PrefixW   = 4;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned DigitW    = 5;
  localparam int unsigned CountW    = 4;

  localparam logic [DigitW-1:0] EndToken  = 5'd26;
  localparam logic [CountW-1:0] MaxDigits = 4'd13;
  localparam logic [ByteW-1:0]  CharA     = 8'h61;
  localparam logic [ByteW-1:0]  CharZ     = 8'h7a;
  localparam logic [ByteW-1:0]  CharSpace = 8'h20;
  localparam logic [WordW-1:0]  Pow13     = 62'd4052555153018976267;

  // one result beat
  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last;
  } wrp_beat_t;

  // results produced by one item, in order: first then second
  typedef struct packed {
    logic [1:0] num;
    wrp_beat_t  first;
    wrp_beat_t  second;
  } wrp_push_t;

  // 27 to the power k, k below thirteen
  function automatic logic [WordW-1:0] pow27(input logic [CountW-1:0] k);
    logic [WordW-1:0] p;
    unique case (k)
      4'd0:    p = 62'd1;
      4'd1:    p = 62'd27;
      4'd2:    p = 62'd729;
      4'd3:    p = 62'd19683;
      4'd4:    p = 62'd531441;
      4'd5:    p = 62'd14348907;
      4'd6:    p = 62'd387420489;
      4'd7:    p = 62'd10460353203;
      4'd8:    p = 62'd282429536481;
      4'd9:    p = 62'd7625597484987;
      4'd10:   p = 62'd205891132094649;
      4'd11:   p = 62'd5559060566555523;
      4'd12:   p = 62'd150094635296999121;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/word_radix27_packer_core.sv
// radix-27 word packer: an input beat passes the input register, then the result queue, before its first result beat
// throughput one input beat per cycle while the input is not stalled; a flush closing a full word gives two beats
// a single digit multiply-accumulate lies between input and queue
// input is stalled only when the result queue holds more than two beats
// asynchronous active-low reset: empty queue, between words, prefix_len 1
module word_radix27_packer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: prefix_len
  input  logic                         cfg_we_i,
  input  logic [wrp_pkg::PrefixW-1:0]  cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [wrp_pkg::ByteW-1:0]    in_byte_i,
  input  logic                         flush_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [wrp_pkg::WordW-1:0]    packed_word_o,
  output logic                         last_o
);
  import wrp_pkg::*;

  // input register
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_flush_q;
  logic             in_accept;

  // processing handshake towards the queue
  logic             room;
  logic             fire;
  wrp_push_t        push;
  wrp_beat_t        beat;

  // item in the input register is processed once the queue can take two beats
  assign fire       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept || (in_valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q  <= in_byte_i;
      in_flush_q <= flush_i;
    end
  end

  // word state and digit packing, works on the registered beat
  wrp_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .flush_i     (in_flush_q),
    .push_o      (push)
  );

  // result queue parts the result side from the input side
  wrp_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (fire),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .beat_o      (beat)
  );

  assign packed_word_o = beat.word;
  assign last_o        = beat.last;

endmodule

// File: rtl/wrp_engine.sv
// word state, prefix counter and digit multiply-accumulate of the packer
module wrp_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wrp_pkg::PrefixW-1:0]  cfg_wdata_i,
  input  logic                         fire_i,
  input  logic [wrp_pkg::ByteW-1:0]    byte_i,
  input  logic                         flush_i,
  output wrp_pkg::wrp_push_t           push_o
);
  import wrp_pkg::*;

  typedef enum logic [1:0] {
    PhBetween = 2'd0,
    PhPrefix  = 2'd1,
    PhLetters = 2'd2
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [PrefixW-1:0] left_q, left_d;
  logic [PrefixW-1:0] prefix_len_q;
  logic [WordW-1:0]   acc_q, acc_d;
  logic [CountW-1:0]  cnt_q, cnt_d;

  logic               is_letter;
  logic [DigitW-1:0]  letter_digit;
  logic               take;
  logic [DigitW-1:0]  digit;
  logic               full;
  logic [WordW-1:0]   prod;
  logic [WordW-1:0]   acc_dig, acc_mid;
  logic [CountW-1:0]  cnt_dig, cnt_mid;
  logic               emit_full, emit_flush;
  logic [ByteW-1:0]   letter_off;

  assign is_letter    = (byte_i >= CharA) && (byte_i <= CharZ);
  assign letter_off   = byte_i - CharA;
  assign letter_digit = letter_off[DigitW-1:0];

  // phase sequencing
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    take    = 1'b0;
    digit   = EndToken;
    if (flush_i) begin
      take = (phase_q == PhPrefix) || (phase_q == PhLetters);
    end else begin
      unique case (phase_q)
        PhPrefix: begin
          if (left_q != '0) left_d = left_q - 1'b1;
          if (left_d == '0) phase_d = PhLetters;
        end
        PhLetters: begin
          take    = 1'b1;
          digit   = is_letter ? letter_digit : EndToken;
          phase_d = is_letter ? PhLetters : PhBetween;
        end
        default: begin
          phase_d = PhBetween;
          if (byte_i > CharSpace) begin
            if (prefix_len_q == '0) begin
              take    = 1'b1;
              digit   = is_letter ? letter_digit : EndToken;
              phase_d = is_letter ? PhLetters : PhBetween;
            end else begin
              left_d  = prefix_len_q - 1'b1;
              phase_d = (left_d != '0) ? PhPrefix : PhLetters;
            end
          end
        end
      endcase
    end
  end

  // digit accumulate, wraps to a fresh word after thirteen digits
  assign full    = (cnt_q == MaxDigits);
  assign prod    = WordW'(digit) * pow27(cnt_q);
  assign acc_dig = full ? WordW'(digit) : acc_q + prod;
  assign cnt_dig = full ? CountW'(1) : cnt_q + 1'b1;
  assign acc_mid = take ? acc_dig : acc_q;
  assign cnt_mid = take ? cnt_dig : cnt_q;

  assign emit_full  = take && full;
  assign emit_flush = flush_i && (cnt_mid != '0);

  always_comb begin
    push_o.num         = {1'b0, emit_full} + {1'b0, emit_flush};
    push_o.first.word  = emit_full ? acc_q : acc_mid;
    push_o.first.last  = !(emit_full && emit_flush);
    push_o.second.word = acc_mid;
    push_o.second.last = 1'b1;
  end

  assign acc_d = flush_i ? '0 : acc_mid;
  assign cnt_d = flush_i ? '0 : cnt_mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhBetween;
      left_q       <= '0;
      acc_q        <= '0;
      cnt_q        <= '0;
      prefix_len_q <= PrefixW'(1);
    end else begin
      if (cfg_we_i) prefix_len_q <= cfg_wdata_i;
      if (fire_i) begin
        phase_q <= flush_i ? PhBetween : phase_d;
        left_q  <= flush_i ? '0 : left_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
      end
    end
  end

endmodule

// File: rtl/wrp_out_fifo.sv
// four-entry result queue, takes up to two beats a cycle and gives one while the output is not stalled
module wrp_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_en_i,
  input  wrp_pkg::wrp_push_t  push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wrp_pkg::wrp_beat_t  beat_o
);
  import wrp_pkg::*;

  wrp_beat_t  mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] count_q, count_d;
  logic [1:0] push_num;
  logic       pop;
  logic [1:0] wr_next;

  assign push_num    = push_en_i ? push_i.num : 2'd0;
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  // space for a pair of beats
  assign room_o      = (count_q <= 3'd2);
  assign beat_o      = mem_q[rd_q];
  assign wr_next     = wr_q + 2'd1;
  assign count_d     = count_q + {1'b0, push_num} - {2'b0, pop};

  always_ff @(posedge clk_i) begin
    if (push_num != 2'd0) mem_q[wr_q]    <= push_i.first;
    if (push_num == 2'd2) mem_q[wr_next] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + push_num;
      if (pop) rd_q <= rd_q + 2'd1;
      count_q <= count_d;
    end
  end

endmodule

// File: rtl/wrp_checker.sv
// port-level checks on the radix-27 word packer, bound to the top level
module wrp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [wrp_pkg::PrefixW-1:0]  cfg_wdata_i,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [wrp_pkg::ByteW-1:0]    in_byte_i,
  input logic                         flush_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [wrp_pkg::WordW-1:0]    packed_word_o,
  input logic                         last_o
);
  import wrp_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(packed_word_o) && $stable(last_o))
    else $error("result beat changed while stalled");

  // packed word never reaches 27^13
  a_word_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> packed_word_o < Pow13)
    else $error("packed word out of range");

  // the first beat of a pair is always followed by its partner
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o && !out_stall_i |=> out_valid_o && last_o)
    else $error("non-final beat without a following beat");

  // with no result pending the input is never stalled
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result queue");

endmodule

bind word_radix27_packer_core wrp_checker u_wrp_checker (.*);
